>>> hdl/br1_pkg.sv
// ----------------------------------------------------------------------------
// br1_pkg
// Shared types and constants for the ByteRun1 planar body decoder.
// ----------------------------------------------------------------------------
package br1_pkg;

  // port and field widths
  localparam int BYTE_W      = 8;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = 4;
  localparam int PLANE_W     = 3;
  localparam int ROW_W       = 16;
  localparam int RB_W        = 13;
  localparam int PC_W        = 4;
  localparam int PBD_W       = 14;
  localparam int RUN_W       = 8;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // control byte codes
  localparam logic [BYTE_W-1:0] CTRL_NOP = 8'd128;
  localparam logic [8:0]        REP_BASE = 9'd257;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ON     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd3;

  // register reset values
  localparam logic [RB_W-1:0]  RST_ROW_BYTES   = 13'd40;
  localparam logic [PC_W-1:0]  RST_PLANE_COUNT = 4'd5;
  localparam logic             RST_MASK_ON     = 1'b0;
  localparam logic [ROW_W-1:0] RST_IMAGE_ROWS  = 16'd256;

  // parser phase
  typedef enum logic [2:0] {
    PH_CTRL = 3'b001,
    PH_LIT  = 3'b010,
    PH_REP  = 3'b100
  } phase_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_beat;
  } br1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_out;
    logic beat_last;
    logic slot_free;
  } br1_sts_t;

endpackage

>>> hdl/br1_ctrl.sv
// ----------------------------------------------------------------------------
// br1_ctrl
// Controller: takes body words while idle, then drives beat emission.
// ----------------------------------------------------------------------------
module br1_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  br1_pkg::br1_sts_t sts,
  output br1_pkg::br1_cmd_t cmd
);
  import br1_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // handshake and commands
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.accept    = in_tready && in_tvalid;
    cmd.load_beat = (state_r == S_EMIT) && sts.slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.has_out) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.load_beat && sts.beat_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/br1_dp.sv
// ----------------------------------------------------------------------------
// br1_dp
// Datapath: configuration registers, parser and plane/row position, run
// latch, beat splitter and output register.
// ----------------------------------------------------------------------------
module br1_dp #(
  parameter int LANE_BYTES = 8,
  parameter int MAX_PLANES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [br1_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [br1_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [br1_pkg::BYTE_W-1:0]        in_byte,
  input  br1_pkg::br1_cmd_t                 cmd,
  output br1_pkg::br1_sts_t                 sts,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [br1_pkg::DATA_W-1:0]        out_data,
  output logic [br1_pkg::CNT_W-1:0]         out_count,
  output logic [br1_pkg::PLANE_W-1:0]       out_plane,
  output logic [br1_pkg::ROW_W-1:0]         out_row,
  output logic                              out_last,
  output logic                              out_done
);
  import br1_pkg::*;

  localparam int                LANES     = DATA_W / BYTE_W;
  localparam logic [RUN_W-1:0]  LANE_RUN  = RUN_W'(LANE_BYTES);
  localparam logic [PC_W-1:0]   PL_MAX    = PC_W'(MAX_PLANES);

  // configuration
  logic [RB_W-1:0]  row_bytes_r, row_bytes_nxt;
  logic [PC_W-1:0]  plane_count_r, plane_count_nxt;
  logic             mask_on_r, mask_on_nxt;
  logic [ROW_W-1:0] image_rows_r, image_rows_nxt;

  // parser position
  phase_t           phase_r, phase_nxt;
  logic [RUN_W-1:0] lit_left_r, lit_left_nxt;
  logic [PBD_W-1:0] pbd_r, pbd_nxt;
  logic [PC_W-1:0]  plane_r, plane_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             fin_r, fin_nxt;

  // run latch
  logic [BYTE_W-1:0]  rbyte_r, rbyte_nxt;
  logic [RUN_W-1:0]   left_r, left_nxt;
  logic [PLANE_W-1:0] tplane_r, tplane_nxt;
  logic [ROW_W-1:0]   trow_r, trow_nxt;
  logic               tdone_r, tdone_nxt;

  // output register
  logic               ovalid_r, ovalid_nxt;
  logic [DATA_W-1:0]  odata_r, odata_nxt;
  logic [CNT_W-1:0]   ocount_r, ocount_nxt;
  logic [PLANE_W-1:0] oplane_r, oplane_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic               olast_r, olast_nxt;
  logic               odone_r, odone_nxt;

  // position arithmetic
  logic [RB_W-1:0]  eff_rb;
  logic [PC_W-1:0]  eff_pl;
  logic             active, visible, is_lit, is_rep;
  logic [RUN_W-1:0] lit_dec, run_len;
  logic [PBD_W-1:0] pbd_sum;
  logic             run_end, full, completes, done;
  logic [PC_W-1:0]  pl_inc;
  logic [PC_W:0]    pl_limit;
  logic             row_wrap, row_fin;
  logic [ROW_W-1:0] row_inc;

  // beat split
  logic [RUN_W-1:0]  beat_k;
  logic [DATA_W-1:0] beat_data;

  always_comb begin
    eff_rb = (row_bytes_r == '0) ? RB_W'(1) : row_bytes_r;
    if (plane_count_r == '0) begin
      eff_pl = PC_W'(1);
    end else if (plane_count_r > PL_MAX) begin
      eff_pl = PL_MAX;
    end else begin
      eff_pl = plane_count_r;
    end
    active    = !fin_r && (row_r < image_rows_r);
    visible   = plane_r < eff_pl;
    is_lit    = (phase_r == PH_LIT);
    is_rep    = (phase_r == PH_REP);
    lit_dec   = (lit_left_r != '0) ? lit_left_r - RUN_W'(1) : '0;
    run_len   = is_lit ? RUN_W'(1) : lit_left_r;
    pbd_sum   = pbd_r + PBD_W'(run_len);
    run_end   = is_rep || (lit_dec == '0);
    full      = pbd_sum >= PBD_W'(eff_rb);
    completes = full
             && ({1'b0, plane_r} + 5'd1 == {1'b0, eff_pl})
             && ({1'b0, row_r} + 17'd1 == {1'b0, image_rows_r});
    done      = run_end && completes;
    pl_inc    = plane_r + PC_W'(1);
    pl_limit  = {1'b0, eff_pl} + {{PC_W{1'b0}}, mask_on_r};
    row_wrap  = {1'b0, pl_inc} >= pl_limit;
    row_inc   = row_r + ROW_W'(1);
    row_fin   = (row_inc >= image_rows_r) || (row_inc == '0);
  end

  // beat of up to LANE_BYTES copies of the run byte
  always_comb begin
    beat_k = (left_r > LANE_RUN) ? LANE_RUN : left_r;
    for (int i = 0; i < LANES; i++) begin
      beat_data[i*BYTE_W +: BYTE_W] = (RUN_W'(i) < beat_k) ? rbyte_r : '0;
    end
  end

  // status
  always_comb begin
    sts.has_out   = active && !(phase_r == PH_CTRL) && visible;
    sts.beat_last = left_r <= LANE_RUN;
    sts.slot_free = !ovalid_r || out_tready;
  end

  // configuration writes
  always_comb begin
    row_bytes_nxt   = row_bytes_r;
    plane_count_nxt = plane_count_r;
    mask_on_nxt     = mask_on_r;
    image_rows_nxt  = image_rows_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ROW_BYTES:   row_bytes_nxt   = cfg_data[RB_W-1:0];
        REG_PLANE_COUNT: plane_count_nxt = cfg_data[PC_W-1:0];
        REG_MASK_ON:     mask_on_nxt     = cfg_data[0];
        REG_IMAGE_ROWS:  image_rows_nxt  = cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // parser and position update on an accepted word
  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    pbd_nxt      = pbd_r;
    plane_nxt    = plane_r;
    row_nxt      = row_r;
    fin_nxt      = fin_r;
    rbyte_nxt    = rbyte_r;
    tplane_nxt   = tplane_r;
    trow_nxt     = trow_r;
    tdone_nxt    = tdone_r;
    left_nxt     = left_r;
    if (cmd.accept && active) begin
      // latch the run for the beat splitter
      rbyte_nxt  = in_byte;
      left_nxt   = run_len;
      tplane_nxt = plane_r[PLANE_W-1:0];
      trow_nxt   = row_r;
      tdone_nxt  = done;
      case (phase_r)
        PH_CTRL: begin
          if (in_byte < CTRL_NOP) begin
            lit_left_nxt = in_byte + RUN_W'(1);
            phase_nxt    = PH_LIT;
          end else if (in_byte > CTRL_NOP) begin
            lit_left_nxt = RUN_W'(REP_BASE - {1'b0, in_byte});
            phase_nxt    = PH_REP;
          end
        end
        PH_LIT, PH_REP: begin
          pbd_nxt      = pbd_sum;
          lit_left_nxt = is_rep ? '0 : lit_dec;
          if (run_end) begin
            phase_nxt = PH_CTRL;
            // end of run: advance plane and row when the plane is full
            if (full) begin
              pbd_nxt   = '0;
              plane_nxt = pl_inc;
              if (row_wrap) begin
                plane_nxt = '0;
                row_nxt   = row_inc;
                if (row_fin) fin_nxt = 1'b1;
              end
            end
          end
        end
        default: phase_nxt = PH_CTRL;
      endcase
    end
    if (cmd.load_beat) left_nxt = left_r - beat_k;
  end

  // output register
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ocount_nxt = ocount_r;
    oplane_nxt = oplane_r;
    orow_nxt   = orow_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    if (cmd.load_beat) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = beat_data;
      ocount_nxt = beat_k[CNT_W-1:0];
      oplane_nxt = tplane_r;
      orow_nxt   = trow_r;
      olast_nxt  = sts.beat_last;
      odone_nxt  = sts.beat_last && tdone_r;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= RST_ROW_BYTES;
      plane_count_r <= RST_PLANE_COUNT;
      mask_on_r     <= RST_MASK_ON;
      image_rows_r  <= RST_IMAGE_ROWS;
      phase_r       <= PH_CTRL;
      lit_left_r    <= '0;
      pbd_r         <= '0;
      plane_r       <= '0;
      row_r         <= '0;
      fin_r         <= 1'b0;
      left_r        <= '0;
      ovalid_r      <= 1'b0;
    end else begin
      row_bytes_r   <= row_bytes_nxt;
      plane_count_r <= plane_count_nxt;
      mask_on_r     <= mask_on_nxt;
      image_rows_r  <= image_rows_nxt;
      phase_r       <= phase_nxt;
      lit_left_r    <= lit_left_nxt;
      pbd_r         <= pbd_nxt;
      plane_r       <= plane_nxt;
      row_r         <= row_nxt;
      fin_r         <= fin_nxt;
      left_r        <= left_nxt;
      ovalid_r      <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rbyte_r  <= rbyte_nxt;
    tplane_r <= tplane_nxt;
    trow_r   <= trow_nxt;
    tdone_r  <= tdone_nxt;
    odata_r  <= odata_nxt;
    ocount_r <= ocount_nxt;
    oplane_r <= oplane_nxt;
    orow_r   <= orow_nxt;
    olast_r  <= olast_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_data   = odata_r;
  assign out_count  = ocount_r;
  assign out_plane  = oplane_r;
  assign out_row    = orow_r;
  assign out_last   = olast_r;
  assign out_done   = odone_r;

endmodule

>>> hdl/byterun1_planar_body_decoder.sv
// ----------------------------------------------------------------------------
// byterun1_planar_body_decoder
// ByteRun1 decoder for an interleaved bitplane image body.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one compressed body byte per word in in_tdata[7:0].
//   out_* : decoded bytes in beats of up to LANE_BYTES bytes, tagged with
//           plane and row; tlast marks the final beat caused by one input
//           word, tuser flags the beat that completes the last image row.
//   cfg_* : register write port, to be taken while the block is idle: the
//           user must keep to this, as the block does not enforce it.
// Beats: a control byte or a byte of the mask plane gives no beat; a
//   literal byte gives one beat; a replicate data byte of n copies gives
//   ceil(n / LANE_BYTES) beats. A single output register holds each beat
//   and a beat counter walks the run. The first beat of a word passes
//   through the run latch and then the output register.
// Reset: registers return to their defaults, the parser waits for a
//   control byte at plane 0, row 0, and no beat is pending.
// Stall: while out_tready is low a pending beat holds and in_tready stays
//   low until the last beat of the run has entered the output register.
// ----------------------------------------------------------------------------
module byterun1_planar_body_decoder #(
  parameter int LANE_BYTES = 8,
  parameter int MAX_PLANES = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [br1_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [br1_pkg::CFG_DATA_W-1:0]        cfg_data,
  // compressed words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] body_byte
  // decoded words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [63:0] data_bytes, [67:64] byte_count, [70:68] plane_number,
  // [86:71] row_number, [87] zero
  output logic [br1_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,  // last_of_input
  output logic                                  out_tuser   // [0] image_done
);
  import br1_pkg::*;

  br1_cmd_t           cmd;
  br1_sts_t           sts;
  logic [DATA_W-1:0]  o_data;
  logic [CNT_W-1:0]   o_count;
  logic [PLANE_W-1:0] o_plane;
  logic [ROW_W-1:0]   o_row;

  br1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  br1_dp #(
    .LANE_BYTES (LANE_BYTES),
    .MAX_PLANES (MAX_PLANES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (o_data),
    .out_count  (o_count),
    .out_plane  (o_plane),
    .out_row    (o_row),
    .out_last   (out_tlast),
    .out_done   (out_tuser)
  );

  // pack result fields low to high
  assign out_tdata = {1'b0, o_row, o_plane, o_count, o_data};

endmodule

>>> hdl/br1_chk.sv
// ----------------------------------------------------------------------------
// br1_chk
// Port checker for the ByteRun1 planar body decoder, bound to the top level.
// ----------------------------------------------------------------------------
module br1_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [br1_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                out_tlast,
  input logic                                out_tuser
);
  import br1_pkg::*;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped while stalled");

  // byte count of an offered word is within one to eight
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[67:64] != 4'd0) && (out_tdata[67:64] <= 4'd8))
    else $error("byte count out of range");

  // image completion only comes on the final word of an input byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("image done without last");

  // no input is taken while a run is still being split, only when idle
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !out_tlast |-> !in_tready)
    else $error("input taken during a run");

endmodule

bind byterun1_planar_body_decoder br1_chk u_br1_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

>>> sim/tb_byterun1_planar_body_decoder.sv
// ----------------------------------------------------------------------------
// tb_byterun1_planar_body_decoder
// Feeds ByteRun1 compressed body bytes into the decoder under bursty input
// and a stalling output side. A predictor follows control bytes, plane, row
// and mask-plane bookkeeping and checks every decoded word field by field.
// ----------------------------------------------------------------------------
module tb_byterun1_planar_body_decoder;
  import br1_pkg::*;

  localparam int LANES         = 8;
  localparam int PLANES_MAX    = 8;
  localparam int RANDOM_WORDS  = 12;    // counted body bytes per random phase
  localparam int SETTLE_CYCLES = 24;    // latency plus a full run of beats
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake

  // opening bytes at the default geometry: both byte extremes, a no-op,
  // the longest replicate, a two-beat replicate and a short literal
  localparam logic [7:0] OPENING_BYTES [13] = '{
    8'd0, 8'hFF, CTRL_NOP, 8'd129, 8'hA5, 8'd255, 8'h00,
    8'd248, 8'h3C, 8'd2, 8'h01, 8'h80, 8'h7F
  };
  // bytes with one-byte planes, a clamped plane count and a mask plane
  localparam logic [7:0] MASK_BYTES [7] = '{
    8'd1, 8'h11, 8'h22, 8'd254, 8'h77, 8'd0, 8'h99
  };

  // one decoded word as it should leave the block
  typedef struct {
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   count;
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    logic               last;
    logic               done;
  } decoded_beat_t;

  // predicts decoded words from accepted body bytes and matches the outputs
  class decoded_beat_board;
    logic [RB_W-1:0]  row_bytes;
    logic [PC_W-1:0]  plane_count;
    logic             mask_on;
    logic [ROW_W-1:0] image_rows;

    phase_t            parse_phase;
    int unsigned       run_left;
    logic [PBD_W-1:0]  plane_fill;
    logic [3:0]        plane_idx;
    logic [ROW_W-1:0]  row_idx;
    bit                finished;

    decoded_beat_t beats_due[$];
    int unsigned   mismatch_count;

    function new();
      row_bytes      = RST_ROW_BYTES;
      plane_count    = RST_PLANE_COUNT;
      mask_on        = RST_MASK_ON;
      image_rows     = RST_IMAGE_ROWS;
      parse_phase    = PH_CTRL;
      run_left       = 0;
      plane_fill     = '0;
      plane_idx      = '0;
      row_idx        = '0;
      finished       = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROW_BYTES:   row_bytes   = val[RB_W-1:0];
        REG_PLANE_COUNT: plane_count = val[PC_W-1:0];
        REG_MASK_ON:     mask_on     = val[0];
        default:         image_rows  = val[ROW_W-1:0];
      endcase
    endfunction

    function int unsigned eff_row_bytes();
      return (row_bytes == 0) ? 1 : 32'(row_bytes);
    endfunction

    function int unsigned eff_planes();
      if (plane_count == 0) return 1;
      if (plane_count > PLANES_MAX) return PLANES_MAX;
      return 32'(plane_count);
    endfunction

    // a run ending here delivers the last byte of the image data
    function bit completes_image();
      return 32'(plane_fill) >= eff_row_bytes()
          && 32'(plane_idx) + 1 == eff_planes()
          && 32'(row_idx) + 1 == 32'(image_rows);
    endfunction

    // plane and row advance only when a run leaves the plane full
    function void close_run();
      if (32'(plane_fill) < eff_row_bytes()) return;
      plane_fill = '0;
      plane_idx  = 4'(plane_idx + 1);
      if (32'(plane_idx) >= eff_planes() + 32'(mask_on)) begin
        plane_idx = '0;
        row_idx   = 16'(row_idx + 1);
        if (row_idx >= image_rows || row_idx == 0) finished = 1'b1;
      end
    endfunction

    function void queue_beat(logic [DATA_W-1:0] data, int unsigned count, bit last, bit done);
      decoded_beat_t b;
      b.data  = data;
      b.count = CNT_W'(count);
      b.plane = plane_idx[PLANE_W-1:0];
      b.row   = row_idx;
      b.last  = last;
      b.done  = done;
      beats_due.push_back(b);
    endfunction

    function bit ignoring();
      return finished || row_idx >= image_rows;
    endfunction

    // note one accepted body byte
    function void take_byte(logic [7:0] body);
      bit shown;
      bit run_end;
      bit done;
      int unsigned total;
      int unsigned left;
      int unsigned k;
      logic [DATA_W-1:0] data;
      if (ignoring()) return;
      shown = 32'(plane_idx) < eff_planes();
      case (parse_phase)
        PH_CTRL: begin
          if (body < CTRL_NOP) begin
            run_left    = 32'(body) + 1;
            parse_phase = PH_LIT;
          end else if (body > CTRL_NOP) begin
            run_left    = 32'(REP_BASE) - 32'(body);
            parse_phase = PH_REP;
          end
        end
        PH_LIT: begin
          plane_fill = PBD_W'(plane_fill + 1);
          if (run_left > 0) run_left--;
          run_end = (run_left == 0);
          done    = run_end && completes_image();
          if (shown) queue_beat(DATA_W'(body), 1, 1'b1, done);
          if (run_end) begin
            parse_phase = PH_CTRL;
            close_run();
          end
        end
        default: begin
          // replicate data byte: the whole run goes out in lane-wide words
          total      = run_left;
          plane_fill = PBD_W'(32'(plane_fill) + total);
          done       = completes_image();
          if (shown) begin
            left = total;
            while (left > 0) begin
              k    = (left > LANES) ? LANES : left;
              data = '0;
              for (int i = 0; i < int'(k); i++) data |= DATA_W'(body) << (8 * i);
              left -= k;
              queue_beat(data, k, left == 0, left == 0 && done);
            end
          end
          run_left    = 0;
          parse_phase = PH_CTRL;
          close_run();
        end
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    // match one accepted output word against the oldest expectation
    function void match_beat(logic [OUT_TDATA_W-1:0] tdata, logic tlast, logic tuser);
      decoded_beat_t b;
      if (beats_due.size() == 0) begin
        $error("word with nothing expected: data_bytes %0h", tdata[DATA_W-1:0]);
        mismatch_count++;
        return;
      end
      b = beats_due.pop_front();
      check_field("data_bytes", b.data, tdata[DATA_W-1:0]);
      check_field("byte_count", 64'(b.count), 64'(tdata[DATA_W +: CNT_W]));
      check_field("plane_number", 64'(b.plane), 64'(tdata[DATA_W+CNT_W +: PLANE_W]));
      check_field("row_number", 64'(b.row), 64'(tdata[DATA_W+CNT_W+PLANE_W +: ROW_W]));
      check_field("last_of_input", 64'(b.last), 64'(tlast));
      check_field("image_done", 64'(b.done), 64'(tuser));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;

  decoded_beat_board store;
  int unsigned       burst_left   = 0;
  int unsigned       live_words   = 0;
  int unsigned       stall_mode   = 0;
  int unsigned       stall_left   = 0;
  int unsigned       quiet_cycles = 0;

  byterun1_planar_body_decoder #(
    .LANE_BYTES(LANES),
    .MAX_PLANES(PLANES_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, redrawn at random when the current one runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) == 1);
      2:       out_tready <= (stall_left % 4 == 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // output word check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) store.match_beat(out_tdata, out_tlast, out_tuser);
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_byterun1_planar_body_decoder NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one body byte, with bursts and random gaps on the sending side
  task automatic send_byte(input logic [7:0] body);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= body;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!store.ignoring()) live_words++;
    store.take_byte(body);
    burst_left--;
  endtask

  // write all four registers back to back
  task automatic set_regs(input int unsigned rb, input int unsigned pc,
                          input int unsigned mask, input int unsigned rows);
    logic [CFG_IDX_W-1:0] idx [4];
    int unsigned          val [4];
    idx = '{REG_ROW_BYTES, REG_PLANE_COUNT, REG_MASK_ON, REG_IMAGE_ROWS};
    val = '{rb, pc, mask, rows};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CFG_DATA_W'(val[i]);
      @(posedge clk);
      store.write_reg(idx[i], CFG_DATA_W'(val[i]));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, drain all expected words, then cover the pipeline latency
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (store.beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed runs with random content, some no-ops and stray bytes
  task automatic send_packet();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 128) : $urandom_range(1, 8);
      send_byte(8'(len - 1));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 128) : $urandom_range(2, 16);
      send_byte(8'(32'(REP_BASE) - len));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      send_byte(CTRL_NOP);
    end else begin
      // stray byte that shifts the run framing
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // finish an open run so the parser waits for a control byte
  task automatic close_open_run();
    while (store.parse_phase != PH_CTRL && !store.ignoring())
      send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(input int unsigned rb, input int unsigned pc,
                              input int unsigned mask, input int unsigned rows);
    int unsigned start;
    set_regs(rb, pc, mask, rows);
    start = live_words;
    while (live_words - start < RANDOM_WORDS) send_packet();
    close_open_run();
    settle();
  endtask

  initial begin
    int unsigned guard;
    store     = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_ROW_BYTES;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed runs at the reset geometry
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    settle();

    // one-byte planes, zero plane count, mask plane skipped
    set_regs(1, 0, 1, 65535);
    foreach (MASK_BYTES[i]) send_byte(MASK_BYTES[i]);
    settle();

    // random traffic over several geometries, extremes included
    random_phase(2, 3, 0, 65535);
    random_phase(1, 8, 1, 65535);
    random_phase(8191, 15, 0, 65535);
    random_phase(0, 1, 1, 65535);
    random_phase($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 1), 65535);
    random_phase($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 1), 65535);

    // image cut off at the current row, then an empty image: nothing comes out
    set_regs(4, 2, 0, 32'(store.row_idx));
    repeat (4) send_packet();
    settle();
    set_regs(4, 2, 0, 0);
    repeat (4) send_packet();
    settle();

    // last two rows with a mask plane, then bytes after the image end
    set_regs(3, 2, 1, 32'(store.row_idx) + 2);
    guard = 0;
    while (!store.finished && guard < 400) begin
      send_packet();
      guard++;
    end
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    settle();

    if (store.mismatch_count == 0 && store.beats_due.size() == 0) begin
      $display("tb_byterun1_planar_body_decoder OK");
    end else begin
      $display("tb_byterun1_planar_body_decoder NOT OK");
    end
    $finish;
  end

endmodule
